// File: rtl/rolling_error_statistics_settle_macros.svh
// Assertion macros used by the top RTL file of the error statistics block.
`ifndef ROLLING_ERROR_STATISTICS_SETTLE_MACROS_SVH
`define ROLLING_ERROR_STATISTICS_SETTLE_MACROS_SVH
`ifndef SYNTHESIS
`define RES_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define RES_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define RES_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RES_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/res_pkg.sv
package res_pkg;

    localparam int RES_WINDOW_DEPTH = 512;

    localparam int ERR_W      = 20;
    localparam int SQ_W       = 39;
    localparam int EMA_W      = 40;
    localparam int VAR_W      = 38;
    localparam int QUOT_W     = 39;
    localparam int MUL_W      = 64;
    localparam int TDATA_IN_W = 64;
    localparam int TDATA_OUT_W = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 38;

    localparam logic [1:0] REG_ERR_LIMIT  = 2'd0;
    localparam logic [1:0] REG_VAR_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TICK_COUNT = 2'd2;
    localparam logic [1:0] REG_EMA_WEIGHT = 2'd3;

    localparam logic [18:0] RST_ERR_LIMIT  = 19'd5702;
    localparam logic [37:0] RST_VAR_LIMIT  = 38'd12884902;
    localparam logic [15:0] RST_TICK_COUNT = 16'd200;
    localparam logic [15:0] RST_EMA_WEIGHT = 16'd328;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQUARE,
        OP_WINDOW,
        OP_MUL_STEP,
        OP_EMA_APPLY,
        OP_STATS,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic seeded;
        logic mul_done;
        logic div_done;
    } dp_status_t;

endpackage

// File: rtl/res_ctrl.sv
module res_ctrl
    import res_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_WINDOW,
        ST_EMA_RUN,
        ST_STATS,
        ST_NUM_RUN,
        ST_DIV_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_IDLE;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.op     = OP_SQUARE;
                state_next = ST_WINDOW;
            end
            ST_WINDOW: begin
                cmd.op     = OP_WINDOW;
                state_next = status.seeded ? ST_EMA_RUN : ST_STATS;
            end
            ST_EMA_RUN: begin
                if (status.mul_done) begin
                    cmd.op     = OP_EMA_APPLY;
                    state_next = ST_STATS;
                end else begin
                    cmd.op = OP_MUL_STEP;
                end
            end
            ST_STATS: begin
                cmd.op     = OP_STATS;
                state_next = ST_NUM_RUN;
            end
            ST_NUM_RUN: begin
                if (status.mul_done) begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DIV_RUN;
                end else begin
                    cmd.op = OP_MUL_STEP;
                end
            end
            ST_DIV_RUN: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.op       = OP_FINISH;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/res_dpath.sv
module res_dpath
    import res_pkg::*;
#(
    parameter int WINDOW_DEPTH = RES_WINDOW_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic signed [31:0]      target_angle,
    input  logic signed [31:0]      actual_angle,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic signed [ERR_W-1:0] angle_error,
    output logic                    error_clipped,
    output logic [ERR_W-1:0]        rms_error,
    output logic [VAR_W-1:0]        window_variance,
    output logic                    variance_valid,
    output logic                    settled
);

    localparam int PW   = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = ERR_W + $clog2(WINDOW_DEPTH);
    localparam int SSW  = SQ_W + $clog2(WINDOW_DEPTH);
    localparam int NNW  = 2 * CW;
    localparam int MBW  = (CW > 16) ? CW : 16;
    localparam logic [PW-1:0] WP_LAST = PW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW_DEPTH);
    localparam logic signed [32:0] ERR_MAX33 = 33'sd524287;
    localparam logic signed [32:0] ERR_MIN33 = -33'sd524288;
    localparam logic [VAR_W-1:0] VAR_ONES = '1;
    localparam logic [ERR_W-1:0] RMS_MAX = 20'd524288;

    logic signed [ERR_W-1:0] mem [WINDOW_DEPTH];

    logic signed [ERR_W-1:0] err_reg, old_reg;
    logic                    clip_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [PW-1:0]           wp_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [SUMW-1:0]  sum_reg;
    logic [SSW-1:0]          ssq_reg;
    logic [EMA_W-1:0]        s_reg;
    logic                    seeded_reg;
    logic                    neg_reg;
    logic [MUL_W-1:0]        ma_reg, acc_reg, mag2_reg;
    logic [MBW-1:0]          mb_reg;
    logic [NNW-1:0]          nn_reg, rem_reg;
    logic [QUOT_W-1:0]       qb_reg;
    logic [5:0]              dcnt_reg;
    logic [EMA_W-1:0]        sx_reg, sr_reg, sbit_reg;
    logic [15:0]             quiet_reg;
    logic [18:0]             err_limit_reg;
    logic [37:0]             var_limit_reg;
    logic [15:0]             tick_count_reg;
    logic [15:0]             weight_reg;

    logic signed [ERR_W-1:0] r_err_reg;
    logic                    r_clip_reg, r_valid_reg, r_settled_reg;
    logic [ERR_W-1:0]        r_rms_reg;
    logic [VAR_W-1:0]        r_var_reg;

    logic signed [32:0]      diff;
    logic                    full;
    logic [SQ_W-1:0]         old_sq;
    logic signed [EMA_W+1:0] ema_diff;
    logic [EMA_W+1:0]        ema_mag;
    logic [57:0]             prod;
    logic signed [57:0]      prod_s, ema_step, ema_sum;
    logic [SUMW-1:0]         mag;
    logic [2*SUMW-1:0]       mag_sq;
    logic [MUL_W-1:0]        num;
    logic [NNW:0]            trial;
    logic [EMA_W-1:0]        sq_try;
    logic                    valid_now;
    logic [VAR_W-1:0]        var_now;
    logic [ERR_W-1:0]        aerr;
    logic                    quiet_now;
    logic [15:0]             quiet_next;

    always_comb begin
        diff      = {actual_angle[31], actual_angle} - {target_angle[31], target_angle};
        full      = (cnt_reg == CNT_FULL);
        old_sq    = SQ_W'(old_reg * old_reg);
        ema_diff  = $signed({3'b000, sq_reg}) - $signed({2'b00, s_reg});
        ema_mag   = ema_diff[EMA_W+1] ? (EMA_W+2)'(-ema_diff) : ema_diff;
        prod      = acc_reg[57:0];
        prod_s    = neg_reg ? -$signed(prod) : $signed(prod);
        ema_step  = prod_s >>> 16;
        ema_sum   = $signed({18'd0, s_reg}) + ema_step;
        mag       = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : sum_reg;
        mag_sq    = mag * mag;
        num       = (acc_reg > mag2_reg) ? acc_reg - mag2_reg : '0;
        trial     = {rem_reg, qb_reg[QUOT_W-1]};
        sq_try    = sr_reg + sbit_reg;
        valid_now = (cnt_reg >= CW'(2));
        if (!valid_now) begin
            var_now = VAR_ONES;
        end else if (qb_reg > QUOT_W'(VAR_ONES)) begin
            var_now = VAR_ONES;
        end else begin
            var_now = qb_reg[VAR_W-1:0];
        end
        aerr       = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : err_reg;
        quiet_now  = valid_now && (aerr < {1'b0, err_limit_reg})
                     && (var_now < var_limit_reg);
        quiet_next = quiet_now ? ((quiet_reg == 16'hFFFF) ? quiet_reg : quiet_reg + 16'd1)
                               : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_SQUARE) begin
            old_reg <= mem[wp_reg];
        end
        if (cmd.op == OP_WINDOW) begin
            mem[wp_reg] <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            ssq_reg        <= '0;
            s_reg          <= '0;
            seeded_reg     <= 1'b0;
            quiet_reg      <= '0;
            err_limit_reg  <= RST_ERR_LIMIT;
            var_limit_reg  <= RST_VAR_LIMIT;
            tick_count_reg <= RST_TICK_COUNT;
            weight_reg     <= RST_EMA_WEIGHT;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ERR_LIMIT:  err_limit_reg  <= cfg_data[18:0];
                    REG_VAR_LIMIT:  var_limit_reg  <= cfg_data[37:0];
                    REG_TICK_COUNT: tick_count_reg <= cfg_data[15:0];
                    REG_EMA_WEIGHT: weight_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD: begin
                    if (diff > ERR_MAX33) begin
                        err_reg  <= ERR_MAX33[ERR_W-1:0];
                        clip_reg <= 1'b1;
                    end else if (diff < ERR_MIN33) begin
                        err_reg  <= ERR_MIN33[ERR_W-1:0];
                        clip_reg <= 1'b1;
                    end else begin
                        err_reg  <= diff[ERR_W-1:0];
                        clip_reg <= 1'b0;
                    end
                end
                OP_SQUARE: begin
                    sq_reg <= SQ_W'(err_reg * err_reg);
                end
                OP_WINDOW: begin
                    sum_reg <= sum_reg - (full ? SUMW'(old_reg) : '0) + SUMW'(err_reg);
                    ssq_reg <= ssq_reg - (full ? SSW'(old_sq) : '0) + SSW'(sq_reg);
                    wp_reg  <= (wp_reg == WP_LAST) ? '0 : wp_reg + PW'(1);
                    if (!full) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    neg_reg <= ema_diff[EMA_W+1];
                    ma_reg  <= MUL_W'(ema_mag);
                    mb_reg  <= MBW'(weight_reg);
                    acc_reg <= '0;
                    if (!seeded_reg) begin
                        s_reg      <= EMA_W'(sq_reg);
                        seeded_reg <= 1'b1;
                    end
                end
                OP_MUL_STEP: begin
                    if (mb_reg[0]) begin
                        acc_reg <= acc_reg + ma_reg;
                    end
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg >> 1;
                end
                OP_EMA_APPLY: begin
                    s_reg <= ema_sum[EMA_W-1:0];
                end
                OP_STATS: begin
                    nn_reg   <= NNW'(cnt_reg) * NNW'(cnt_reg);
                    mag2_reg <= MUL_W'(mag_sq);
                    ma_reg   <= MUL_W'(ssq_reg);
                    mb_reg   <= MBW'(cnt_reg);
                    acc_reg  <= '0;
                end
                OP_DIV_START: begin
                    rem_reg  <= NNW'(num >> QUOT_W);
                    qb_reg   <= num[QUOT_W-1:0];
                    dcnt_reg <= 6'(QUOT_W);
                    sx_reg   <= s_reg;
                    sr_reg   <= '0;
                    sbit_reg <= EMA_W'(1) << (EMA_W - 2);
                end
                OP_DIV_STEP: begin
                    if (trial >= {1'b0, nn_reg}) begin
                        rem_reg <= NNW'(trial - {1'b0, nn_reg});
                        qb_reg  <= {qb_reg[QUOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[NNW-1:0];
                        qb_reg  <= {qb_reg[QUOT_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 6'd1;
                    if (sbit_reg != '0) begin
                        if (sx_reg >= sq_try) begin
                            sx_reg <= sx_reg - sq_try;
                            sr_reg <= (sr_reg >> 1) + sbit_reg;
                        end else begin
                            sr_reg <= sr_reg >> 1;
                        end
                        sbit_reg <= sbit_reg >> 2;
                    end
                end
                OP_FINISH: begin
                    quiet_reg     <= quiet_next;
                    r_err_reg     <= err_reg;
                    r_clip_reg    <= clip_reg;
                    r_rms_reg     <= (sr_reg > EMA_W'(RMS_MAX)) ? RMS_MAX : sr_reg[ERR_W-1:0];
                    r_var_reg     <= var_now;
                    r_valid_reg   <= valid_now;
                    r_settled_reg <= (quiet_next >= tick_count_reg);
                end
                default: ;
            endcase
        end
    end

    assign status.seeded   = seeded_reg;
    assign status.mul_done = (mb_reg == '0);
    assign status.div_done = (dcnt_reg == '0);

    assign angle_error     = r_err_reg;
    assign error_clipped   = r_clip_reg;
    assign rms_error       = r_rms_reg;
    assign window_variance = r_var_reg;
    assign variance_valid  = r_valid_reg;
    assign settled         = r_settled_reg;

endmodule

// File: rtl/rolling_error_statistics_settle.sv
// Rolling angle error statistics with settle detection.
// The s_ channel takes one transaction per control tick carrying the target
// and actual angles; the m_ channel returns one transaction per tick with the
// saturated error, the RMS of its smoothed square, the window variance and
// the settled flag. The cfg_ channel writes the four settle and smoothing
// registers and is always ready; it is to be written only while the block is
// idle, a rule for the user that the block itself does not enforce. A tick is
// worked on alone: the window is read and updated, the bit-serial multiplier
// runs up to sixteen steps for the smoothing product and as many steps as the
// sample count has bits for the variance numerator, then a restoring divider
// runs thirty-nine steps with the square root beside it. The next transaction
// is accepted in the cycle after the result enters the output register. If
// the receiver stalls, the result waits there and the following transaction
// is fully computed before the block holds in its final state.
// Reset clears the window count, sums, smoothing and quiet counter and loads
// the register defaults; the window store itself needs no clearing.
`include "rolling_error_statistics_settle_macros.svh"
module rolling_error_statistics_settle
    import res_pkg::*;
#(
    parameter int WINDOW_DEPTH = RES_WINDOW_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // target_angle [31:0], actual_angle [63:32]
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // angle_error [19:0], error_clipped [20], rms_error [40:21],
    // window_variance [78:41], variance_valid [79], settled [80]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic signed [ERR_W-1:0] angle_error;
    logic              error_clipped;
    logic [ERR_W-1:0]  rms_error;
    logic [VAR_W-1:0]  window_variance;
    logic              variance_valid;
    logic              settled;

    res_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    res_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .target_angle    (s_tdata[31:0]),
        .actual_angle    (s_tdata[63:32]),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .angle_error     (angle_error),
        .error_clipped   (error_clipped),
        .rms_error       (rms_error),
        .window_variance (window_variance),
        .variance_valid  (variance_valid),
        .settled         (settled)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'd0, settled, variance_valid, window_variance, rms_error,
                        error_clipped, angle_error};

    `RES_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `RES_ASSERT_IMP(a_invalid_all_ones, aclk, aresetn, m_tvalid && !variance_valid, &window_variance)
    `RES_ASSERT_IMP(a_rms_bounded, aclk, aresetn, m_tvalid, m_tdata[40:21] <= 20'd524288)

endmodule

// File: verif/res_stats_checker.sv
module res_stats_checker
    import res_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic        settled;
        logic        variance_valid;
        logic [37:0] window_variance;
        logic [19:0] rms_error;
        logic        error_clipped;
        logic [19:0] angle_error;
    } tick_result_t;

    localparam longint ERR_HI = 524287;
    localparam longint ERR_LO = -524288;
    localparam longint VAR_ONES = (64'd1 << 38) - 1;

    longint      err_store [RES_WINDOW_DEPTH];
    int          wr_slot;
    int          held;
    longint      err_total;
    longint      sq_total;
    longint      smoothed;
    bit          seeded;
    int          quiet;
    logic [18:0] err_limit;
    logic [37:0] var_limit;
    logic [15:0] tick_goal;
    logic [15:0] alpha;

    tick_result_t expected_ticks [$];

    assign pending_count = expected_ticks.size();

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic tick_result_t predict_tick(logic [63:0] d);
        tick_result_t res;
        longint diff;
        longint e;
        longint sq;
        longint p;
        longint stp;
        longint rms;
        longint mag;
        longint na;
        longint nb;
        longint num;
        longint vr;
        longint n;
        bit     ok;
        diff = longint'($signed(d[63:32])) - longint'($signed(d[31:0]));
        res.error_clipped = 1'b1;
        if (diff > ERR_HI) e = ERR_HI;
        else if (diff < ERR_LO) e = ERR_LO;
        else begin
            e = diff;
            res.error_clipped = 1'b0;
        end
        sq = e * e;
        if (held >= RES_WINDOW_DEPTH) begin
            err_total -= err_store[wr_slot];
            sq_total -= err_store[wr_slot] * err_store[wr_slot];
        end else begin
            held++;
        end
        err_store[wr_slot] = e;
        err_total += e;
        sq_total += sq;
        wr_slot = (wr_slot + 1) % RES_WINDOW_DEPTH;
        if (!seeded) begin
            smoothed = sq;
            seeded = 1;
        end else begin
            p = longint'(alpha) * (sq - smoothed);
            if (p >= 0) stp = p >>> 16;
            else stp = -((-p + 65535) >>> 16);
            smoothed = smoothed + stp;
        end
        smoothed = smoothed & ((64'd1 << 40) - 1);
        rms = int_sqrt(smoothed);
        if (rms > 524288) rms = 524288;
        if (held < 2) begin
            ok = 0;
            vr = VAR_ONES;
        end else begin
            n = held;
            mag = err_total < 0 ? -err_total : err_total;
            na = n * sq_total;
            nb = mag * mag;
            num = na > nb ? na - nb : 0;
            ok = 1;
            vr = num / (n * n);
            if (vr > VAR_ONES) vr = VAR_ONES;
        end
        mag = e < 0 ? -e : e;
        if (ok && mag < longint'(err_limit) && vr < longint'(var_limit)) begin
            if (quiet < 65535) quiet++;
        end else begin
            quiet = 0;
        end
        res.angle_error = e[19:0];
        res.rms_error = rms[19:0];
        res.window_variance = vr[37:0];
        res.variance_valid = ok;
        res.settled = quiet >= int'(tick_goal);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            wr_slot = 0;
            held = 0;
            err_total = 0;
            sq_total = 0;
            smoothed = 0;
            seeded = 0;
            quiet = 0;
            err_limit = RST_ERR_LIMIT;
            var_limit = RST_VAR_LIMIT;
            tick_goal = RST_TICK_COUNT;
            alpha = RST_EMA_WEIGHT;
            expected_ticks.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ERR_LIMIT:  err_limit = cfg_data[18:0];
                    REG_VAR_LIMIT:  var_limit = cfg_data;
                    REG_TICK_COUNT: tick_goal = cfg_data[15:0];
                    REG_EMA_WEIGHT: alpha = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_ticks.push_back(predict_tick(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[80:0];
                if (expected_ticks.size() == 0) begin
                    $display("unexpected result transaction");
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.angle_error !== want.angle_error)
                        report_mismatch("angle_error", got.angle_error, want.angle_error);
                    if (got.error_clipped !== want.error_clipped)
                        report_mismatch("error_clipped", got.error_clipped,
                            want.error_clipped);
                    if (got.rms_error !== want.rms_error)
                        report_mismatch("rms_error", got.rms_error, want.rms_error);
                    if (got.window_variance !== want.window_variance)
                        report_mismatch("window_variance", got.window_variance,
                            want.window_variance);
                    if (got.variance_valid !== want.variance_valid)
                        report_mismatch("variance_valid", got.variance_valid,
                            want.variance_valid);
                    if (got.settled !== want.settled)
                        report_mismatch("settled", got.settled, want.settled);
                end
            end
        end
    end

endmodule

// File: verif/tb_rolling_error_statistics_settle.sv
module tb_rolling_error_statistics_settle;
    import res_pkg::*;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending_count;
    int                     cycle_count = 0;
    bit                     stall_on = 1;

    always #5 aclk = ~aclk;

    rolling_error_statistics_settle dut (.*);

    res_stats_checker checker_inst (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("[rolling_error_statistics_settle] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!stall_on) m_tready <= 1;
        else if ($urandom_range(0, 9) < 7) m_tready <= 1;
        else m_tready <= $urandom_range(0, 19) == 0 ? 0 : ($urandom_range(0, 1) == 1);
    end

    task automatic idle_gap();
        int n;
        if (!stall_on || $urandom_range(0, 2) == 0) return;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 4);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_tick(logic signed [31:0] target, logic signed [31:0] actual);
        idle_gap();
        s_tvalid <= 1;
        s_tdata <= {actual, target};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic quiet_run(int count, int spread);
        logic signed [31:0] base;
        repeat (count) begin
            base = $urandom;
            send_tick(base, base + $signed($urandom_range(0, 2 * spread)) - spread);
        end
    endtask

    task automatic random_ticks(int count);
        logic signed [31:0] t;
        int k;
        repeat (count) begin
            t = $urandom;
            k = $urandom_range(0, 9);
            if (k < 6) send_tick(t, t + $signed($urandom_range(0, 8000)) - 4000);
            else if (k < 8) send_tick(t, t + $signed($urandom_range(0, 1200000)) - 600000);
            else send_tick(t, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_tick(32'sd0, 32'sd0);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(32'sd0, 32'sd524287);
        send_tick(32'sd0, -32'sd524288);
        send_tick(32'sd0, 32'sd524288);
        send_tick(32'sd0, -32'sd524289);
        send_tick(32'sh5555_5555, 32'shAAAA_AAAA);
        send_tick(32'shAAAA_AAAA, 32'sh5555_5555);
        send_tick(32'sh0000_FFFF, 32'sh0001_0000);
        drain();
        write_reg(REG_TICK_COUNT, 38'd0);
        write_reg(REG_ERR_LIMIT, 38'h7FFFF);
        write_reg(REG_VAR_LIMIT, 38'h3F_FFFF_FFFF);
        write_reg(REG_EMA_WEIGHT, 38'hFFFF);
        quiet_run(12, 100);
        drain();
        write_reg(REG_TICK_COUNT, 38'd5);
        write_reg(REG_EMA_WEIGHT, 38'd0);
        write_reg(REG_ERR_LIMIT, 38'd0);
        write_reg(REG_VAR_LIMIT, 38'd0);
        quiet_run(3, 10);
        drain();
        write_reg(REG_ERR_LIMIT, 38'd6000);
        write_reg(REG_VAR_LIMIT, 38'd12884902);
        write_reg(REG_TICK_COUNT, 38'd20);
        write_reg(REG_EMA_WEIGHT, 38'd328);
        random_ticks(200);
        quiet_run(60, 3000);
        drain();
        stall_on = 0;
        write_reg(REG_EMA_WEIGHT, 38'($urandom_range(0, 65535)));
        write_reg(REG_TICK_COUNT, 38'($urandom_range(1, 40)));
        random_ticks(80);
        quiet_run(40, 2000);
        drain();
        stall_on = 1;
        write_reg(REG_ERR_LIMIT, 38'd524287);
        write_reg(REG_VAR_LIMIT, {6'd0, 32'($urandom)});
        write_reg(REG_TICK_COUNT, 38'd65535);
        write_reg(REG_EMA_WEIGHT, 38'd1);
        random_ticks(300);
        quiet_run(300, 500);
        drain();
        if (fail_count == 0) begin
            $display("[rolling_error_statistics_settle] OK");
        end else begin
            $display("[rolling_error_statistics_settle] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/res_pkg.sv
rtl/res_ctrl.sv
rtl/res_dpath.sv
rtl/rolling_error_statistics_settle.sv
verif/res_stats_checker.sv
verif/tb_rolling_error_statistics_settle.sv
